// File: sv/cdnu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdnu_pkg: shared types, constants and microcode for the day number unit
// Holds the operation codes, the microcode program, the table of weighted
// year/day steps and the month length table.
// ----------------------------------------------------------------------------
package cdnu_pkg;

  localparam int MAX_YEAR_DEF = 9999;

  // field widths
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int SERIAL_W = 22;

  // internal widths
  localparam int ACC_W  = 25;  // holds the largest serial for any supported year
  localparam int YRS_W  = 16;  // year count up to 65535
  localparam int PC_W   = 6;
  localparam int KIDX_W = 5;
  localparam int LEAP_W = 9;   // {centuries, four-year blocks, years}

  localparam int MONTHS_PER_YEAR = 12;

  // operation codes
  localparam logic [1:0] OP_D2S  = 2'd0;
  localparam logic [1:0] OP_S2D  = 2'd1;
  localparam logic [1:0] OP_NEXT = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

  typedef enum logic [3:0] {
    U_START,
    U_FSTEP,
    U_FMON,
    U_FDAY,
    U_CHECK,
    U_RSTEP,
    U_FIX,
    U_RMON,
    U_DONE
  } uop_t;

  typedef struct packed {
    uop_t              uop;
    logic [KIDX_W-1:0] kidx;
    logic [PC_W-1:0]   target;
  } cw_t;

  typedef struct packed {
    logic [ACC_W-1:0]  days;
    logic [YRS_W-1:0]  years;
    logic [LEAP_W-1:0] mask;
  } step_t;

  localparam int NUM_STEPS = 17;

  localparam logic [PC_W-1:0] PC_START  = 6'd0;
  localparam logic [PC_W-1:0] PC_FSTEP0 = 6'd1;
  localparam logic [PC_W-1:0] PC_FMON   = 6'd18;
  localparam logic [PC_W-1:0] PC_FDAY   = 6'd19;
  localparam logic [PC_W-1:0] PC_CHECK  = 6'd20;
  localparam logic [PC_W-1:0] PC_RSTEP0 = 6'd21;
  localparam logic [PC_W-1:0] PC_FIX    = 6'd38;
  localparam logic [PC_W-1:0] PC_RMON   = 6'd39;
  localparam logic [PC_W-1:0] PC_DONE   = 6'd40;

  // microcode program
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw.uop    = U_DONE;
    cw.kidx   = '0;
    cw.target = '0;
    case (pc) inside
      PC_START: begin
        cw.uop    = U_START;
        cw.target = PC_CHECK;
      end
      [PC_FSTEP0 : PC_FMON - 6'd1]: begin
        cw.uop  = U_FSTEP;
        cw.kidx = KIDX_W'(pc - PC_FSTEP0);
      end
      PC_FMON:  cw.uop = U_FMON;
      PC_FDAY:  cw.uop = U_FDAY;
      PC_CHECK: cw.uop = U_CHECK;
      [PC_RSTEP0 : PC_FIX - 6'd1]: begin
        cw.uop  = U_RSTEP;
        cw.kidx = KIDX_W'(pc - PC_RSTEP0);
      end
      PC_FIX:  cw.uop = U_FIX;
      PC_RMON: cw.uop = U_RMON;
      default: cw.uop = U_DONE;
    endcase
    return cw;
  endfunction

  // weighted steps: 400-year blocks, centuries, four-year blocks, years
  function automatic step_t step_tab(input logic [KIDX_W-1:0] idx);
    step_t s;
    case (idx)
      5'd0:    s = '{days: 25'd18700416, years: 16'd51200, mask: 9'h000};
      5'd1:    s = '{days: 25'd9350208,  years: 16'd25600, mask: 9'h000};
      5'd2:    s = '{days: 25'd4675104,  years: 16'd12800, mask: 9'h000};
      5'd3:    s = '{days: 25'd2337552,  years: 16'd6400,  mask: 9'h000};
      5'd4:    s = '{days: 25'd1168776,  years: 16'd3200,  mask: 9'h000};
      5'd5:    s = '{days: 25'd584388,   years: 16'd1600,  mask: 9'h000};
      5'd6:    s = '{days: 25'd292194,   years: 16'd800,   mask: 9'h000};
      5'd7:    s = '{days: 25'd146097,   years: 16'd400,   mask: 9'h000};
      5'd8:    s = '{days: 25'd73048,    years: 16'd200,   mask: 9'h100};
      5'd9:    s = '{days: 25'd36524,    years: 16'd100,   mask: 9'h080};
      5'd10:   s = '{days: 25'd23376,    years: 16'd64,    mask: 9'h040};
      5'd11:   s = '{days: 25'd11688,    years: 16'd32,    mask: 9'h020};
      5'd12:   s = '{days: 25'd5844,     years: 16'd16,    mask: 9'h010};
      5'd13:   s = '{days: 25'd2922,     years: 16'd8,     mask: 9'h008};
      5'd14:   s = '{days: 25'd1461,     years: 16'd4,     mask: 9'h004};
      5'd15:   s = '{days: 25'd730,      years: 16'd2,     mask: 9'h002};
      5'd16:   s = '{days: 25'd365,      years: 16'd1,     mask: 9'h001};
      default: s = '{days: '0, years: '0, mask: '0};
    endcase
    return s;
  endfunction

  // leap from the collected bits of (year - 1)
  function automatic logic is_leap(input logic [LEAP_W-1:0] w);
    return (w[1:0] == 2'd3) && ((w[6:2] != 5'd24) || (w[8:7] == 2'd3));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (mo)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: sv/calendar_day_number_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_day_number_unit: Gregorian date / day serial converter
// Date to serial, serial to date and next date, serial 1 being 1 January of
// year 1, run by a small microcoded sequencer over one accumulator datapath.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one result. The next request is taken
// only once the unit has handed its result to the output register and
// returned to idle. Invalid inputs finish early. The work is set by the
// microcode: 17 weighted compare-and-subtract steps (400-year blocks,
// centuries, four-year blocks, years) in each direction, then a month
// loop, which peels one month per step and takes one more step to leave.
// A finished result sits in the output register while the next request is
// already being worked on; a result not yet taken holds the program at its
// last step.
module calendar_day_number_unit #(
  parameter int MAX_YEAR = cdnu_pkg::MAX_YEAR_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [1:0]                      in_operation,
  input  wire  [cdnu_pkg::DAY_W-1:0]      in_day,
  input  wire  [cdnu_pkg::MONTH_W-1:0]    in_month,
  input  wire  [cdnu_pkg::YEAR_W-1:0]     in_year,
  input  wire  [cdnu_pkg::SERIAL_W-1:0]   in_serial,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [cdnu_pkg::DAY_W-1:0]      out_day,
  output logic [cdnu_pkg::MONTH_W-1:0]    out_month,
  output logic [cdnu_pkg::YEAR_W-1:0]     out_year,
  output logic [cdnu_pkg::SERIAL_W-1:0]   out_serial,
  output logic                            out_valid_res
);

  localparam int ACC_W = cdnu_pkg::ACC_W;
  localparam int YRS_W = cdnu_pkg::YRS_W;

  localparam int MAX_SERIAL_I = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                + MAX_YEAR / 400;
  localparam logic [ACC_W-1:0] MAX_SERIAL = ACC_W'(MAX_SERIAL_I);
  localparam logic [16:0]      MAX_YEAR_C = 17'(MAX_YEAR);

  cdnu_pkg::st_t                   state_r, state_nxt;
  logic [cdnu_pkg::PC_W-1:0]       pc_r, pc_nxt;
  logic [1:0]                      op_r, op_nxt;
  logic [cdnu_pkg::DAY_W-1:0]      day_r, day_nxt;
  logic [cdnu_pkg::MONTH_W-1:0]    month_r, month_nxt;
  logic [cdnu_pkg::YEAR_W-1:0]     year_r, year_nxt;
  logic [cdnu_pkg::SERIAL_W-1:0]   serial_r, serial_nxt;
  logic [ACC_W-1:0]                acc_r, acc_nxt;
  logic [YRS_W-1:0]                yrs_r, yrs_nxt;
  logic [cdnu_pkg::LEAP_W-1:0]     w_r, w_nxt;
  logic [cdnu_pkg::MONTH_W-1:0]    mo_r, mo_nxt;
  logic [ACC_W-1:0]                ser_r, ser_nxt;
  logic                            ok_r, ok_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [cdnu_pkg::DAY_W-1:0]      out_day_r, out_day_nxt;
  logic [cdnu_pkg::MONTH_W-1:0]    out_month_r, out_month_nxt;
  logic [cdnu_pkg::YEAR_W-1:0]     out_year_r, out_year_nxt;
  logic [cdnu_pkg::SERIAL_W-1:0]   out_serial_r, out_serial_nxt;
  logic                            out_res_r, out_res_nxt;

  cdnu_pkg::cw_t                   cw;
  cdnu_pkg::step_t                 stp;
  logic [cdnu_pkg::DAY_W-1:0]      dim;
  logic [ACC_W-1:0]                day_sum;
  logic                            date_ok;
  logic                            in_xact;

  assign in_ready = (state_r == cdnu_pkg::ST_IDLE);
  assign in_xact  = in_valid && in_ready;

  assign cw      = cdnu_pkg::ucode(pc_r);
  assign stp     = cdnu_pkg::step_tab(cw.kidx);
  assign dim     = cdnu_pkg::month_days(mo_r, cdnu_pkg::is_leap(w_r));
  assign day_sum = acc_r + ACC_W'(day_r);
  assign date_ok = (month_r >= 4'd1) && (month_r <= 4'(cdnu_pkg::MONTHS_PER_YEAR))
                   && (year_r != '0) && ({3'b000, year_r} <= MAX_YEAR_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdnu_pkg::ST_IDLE;
      pc_r        <= cdnu_pkg::PC_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    day_r        <= day_nxt;
    month_r      <= month_nxt;
    year_r       <= year_nxt;
    serial_r     <= serial_nxt;
    acc_r        <= acc_nxt;
    yrs_r        <= yrs_nxt;
    w_r          <= w_nxt;
    mo_r         <= mo_nxt;
    ser_r        <= ser_nxt;
    ok_r         <= ok_nxt;
    out_day_r    <= out_day_nxt;
    out_month_r  <= out_month_nxt;
    out_year_r   <= out_year_nxt;
    out_serial_r <= out_serial_nxt;
    out_res_r    <= out_res_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    op_nxt         = op_r;
    day_nxt        = day_r;
    month_nxt      = month_r;
    year_nxt       = year_r;
    serial_nxt     = serial_r;
    acc_nxt        = acc_r;
    yrs_nxt        = yrs_r;
    w_nxt          = w_r;
    mo_nxt         = mo_r;
    ser_nxt        = ser_r;
    ok_nxt         = ok_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_day_nxt    = out_day_r;
    out_month_nxt  = out_month_r;
    out_year_nxt   = out_year_r;
    out_serial_nxt = out_serial_r;
    out_res_nxt    = out_res_r;

    case (state_r)
      cdnu_pkg::ST_IDLE: begin
        if (in_xact) begin
          op_nxt     = in_operation;
          day_nxt    = in_day;
          month_nxt  = in_month;
          year_nxt   = in_year;
          serial_nxt = in_serial;
          pc_nxt     = cdnu_pkg::PC_START;
          state_nxt  = cdnu_pkg::ST_RUN;
        end
      end
      cdnu_pkg::ST_RUN: begin
        case (cw.uop)
          cdnu_pkg::U_START: begin
            ok_nxt = 1'b1;
            w_nxt  = '0;
            mo_nxt = 4'd1;
            if ((op_r == cdnu_pkg::OP_D2S || op_r == cdnu_pkg::OP_NEXT) && date_ok) begin
              yrs_nxt = YRS_W'(year_r) - 16'd1;
              acc_nxt = '0;
              pc_nxt  = pc_r + 6'd1;
            end else if (op_r == cdnu_pkg::OP_S2D) begin
              acc_nxt = ACC_W'(serial_r);
              pc_nxt  = cw.target;
            end else begin
              ok_nxt = 1'b0;
              pc_nxt = cdnu_pkg::PC_DONE;
            end
          end
          // years to days: take each weighted block that still fits
          cdnu_pkg::U_FSTEP: begin
            if (yrs_r >= stp.years) begin
              yrs_nxt = yrs_r - stp.years;
              acc_nxt = acc_r + stp.days;
              w_nxt   = w_r | stp.mask;
            end
            pc_nxt = pc_r + 6'd1;
          end
          cdnu_pkg::U_FMON: begin
            if (mo_r < month_r) begin
              acc_nxt = acc_r + ACC_W'(dim);
              mo_nxt  = mo_r + 4'd1;
            end else begin
              pc_nxt = pc_r + 6'd1;
            end
          end
          cdnu_pkg::U_FDAY: begin
            if (day_sum == '0) begin
              ok_nxt = 1'b0;
              pc_nxt = cdnu_pkg::PC_DONE;
            end else begin
              acc_nxt = day_sum + ACC_W'(op_r == cdnu_pkg::OP_NEXT);
              pc_nxt  = pc_r + 6'd1;
            end
          end
          cdnu_pkg::U_CHECK: begin
            if (acc_r == '0 || acc_r > MAX_SERIAL) begin
              ok_nxt = 1'b0;
              pc_nxt = cdnu_pkg::PC_DONE;
            end else begin
              ser_nxt = acc_r;
              acc_nxt = acc_r - 25'd1;
              yrs_nxt = '0;
              w_nxt   = '0;
              mo_nxt  = 4'd1;
              pc_nxt  = pc_r + 6'd1;
            end
          end
          // days to years: peel blocks off the zero-based day count
          cdnu_pkg::U_RSTEP: begin
            if (acc_r >= stp.days) begin
              acc_nxt = acc_r - stp.days;
              yrs_nxt = yrs_r + stp.years;
              w_nxt   = w_r | stp.mask;
            end
            pc_nxt = pc_r + 6'd1;
          end
          cdnu_pkg::U_FIX: begin
            acc_nxt = acc_r + 25'd1;
            yrs_nxt = yrs_r + 16'd1;
            pc_nxt  = pc_r + 6'd1;
          end
          cdnu_pkg::U_RMON: begin
            if (mo_r < 4'(cdnu_pkg::MONTHS_PER_YEAR) && acc_r > ACC_W'(dim)) begin
              acc_nxt = acc_r - ACC_W'(dim);
              mo_nxt  = mo_r + 4'd1;
            end else begin
              pc_nxt = pc_r + 6'd1;
            end
          end
          cdnu_pkg::U_DONE: begin
            // wait for the output register to free up
            if (!out_valid_r || out_ready) begin
              out_valid_nxt  = 1'b1;
              out_res_nxt    = ok_r;
              out_day_nxt    = ok_r ? acc_r[cdnu_pkg::DAY_W-1:0] : '0;
              out_month_nxt  = ok_r ? mo_r : '0;
              out_year_nxt   = ok_r ? yrs_r[cdnu_pkg::YEAR_W-1:0] : '0;
              out_serial_nxt = ok_r ? ser_r[cdnu_pkg::SERIAL_W-1:0] : '0;
              state_nxt      = cdnu_pkg::ST_IDLE;
            end
          end
          default: begin
            pc_nxt = cdnu_pkg::PC_DONE;
          end
        endcase
      end
      default: begin
        state_nxt = cdnu_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_day       = out_day_r;
  assign out_month     = out_month_r;
  assign out_year      = out_year_r;
  assign out_serial    = out_serial_r;
  assign out_valid_res = out_res_r;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == cdnu_pkg::ST_RUN && pc_r == cdnu_pkg::PC_START)
    else $error("accepted transaction did not start the program");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdnu_pkg::ST_RUN |-> pc_r <= cdnu_pkg::PC_DONE)
    else $error("step counter ran past the end of the program");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_day == '0 && out_month == '0
                                    && out_year == '0 && out_serial == '0)
    else $error("invalid result carries non-zero fields");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_month >= 4'd1 && out_month <= 4'd12
                                   && out_day >= 5'd1 && out_serial != '0)
    else $error("valid result holds an impossible date");

  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && $past(state_r) == cdnu_pkg::ST_IDLE && state_r == cdnu_pkg::ST_IDLE
    |=> !out_valid_r)
    else $error("result appeared with no transaction in progress");
`endif

endmodule
`default_nettype wire
